// ===== design/lwa_pkg.sv =====
// Package with shared types, codes and defaults of the link wiring autodetect block.
`default_nettype none
package lwa_pkg;

    localparam int COMBO_COUNT_DEF = 8;

    localparam logic [15:0] STALE_MS_RST    = 16'd50;
    localparam logic [15:0] DEBOUNCE_MS_RST = 16'd200;
    localparam logic [15:0] WATCHDOG_MS_RST = 16'd3000;
    localparam logic [15:0] SETTLE_MS_RST   = 16'd1000;

    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        REG_STALE    = 2'd0,
        REG_DEBOUNCE = 2'd1,
        REG_WATCHDOG = 2'd2,
        REG_SETTLE   = 2'd3
    } t_reg_index;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_START  = 2'd1,
        OP_STOP   = 2'd2,
        OP_STATUS = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_RUNNING  = 3'd1,
        MODE_SUCCESS  = 3'd2,
        MODE_FAILED   = 3'd3,
        MODE_REJECTED = 3'd4
    } t_mode;

    typedef struct packed {
        logic [15:0] stale_ms;
        logic [15:0] debounce_ms;
        logic [15:0] watchdog_ms;
        logic [15:0] settle_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0] operation;
        logic       frame_valid;
        logic       port_ready;
        logic       armed;
        logic [2:0] current_wiring;
    } t_item;

    typedef struct packed {
        logic [2:0]  trial_state;
        logic [2:0]  combo_index;
        logic [2:0]  applied_wiring;
        logic [15:0] elapsed_ms;
        logic        start_accepted;
        logic        link_active;
    } t_result;

    function automatic logic [1:0] f_popcount3(input logic [2:0] v);
        return {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
    endfunction

endpackage
`default_nettype wire

// ===== design/lwa_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none
interface lwa_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic       frame_valid;
    logic       port_ready;
    logic       armed;
    logic [2:0] current_wiring;

    modport source (output valid, output operation, output frame_valid, output port_ready,
                    output armed, output current_wiring, input ready);
    modport sink   (input valid, input operation, input frame_valid, input port_ready,
                    input armed, input current_wiring, output ready);
endinterface

interface lwa_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  trial_state;
    logic [2:0]  combo_index;
    logic [2:0]  applied_wiring;
    logic [15:0] elapsed_ms;
    logic        start_accepted;
    logic        link_active;

    modport source (output valid, output trial_state, output combo_index,
                    output applied_wiring, output elapsed_ms, output start_accepted,
                    output link_active, input ready);
    modport sink   (input valid, input trial_state, input combo_index,
                    input applied_wiring, input elapsed_ms, input start_accepted,
                    input link_active, output ready);
endinterface
`default_nettype wire

// ===== design/link_wiring_autodetect.sv =====
// Top level of the link wiring autodetect block: config registers and item pipeline.
// The block takes one item per clock cycle while the result side is not stalled and returns
// one result item for each: the item is held in the input register, then the core updates
// the whole trial state and loads the result register. The rate is set by that state
// update, which covers freshness tracking, watchdog, debounce and the settle step together.
// Configuration writes take effect at once and need no clearing pass; the trial order list
// is rebuilt on every accepted start.
`default_nettype none
module link_wiring_autodetect #(
    parameter int COMBO_COUNT = lwa_pkg::COMBO_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    lwa_in_if.sink           i_in,
    lwa_out_if.source        o_out
);

    lwa_pkg::t_cfg    r_cfg;
    lwa_pkg::t_item   r_item;
    logic             r_in_valid;
    lwa_pkg::t_result r_res;
    logic             r_out_valid;

    lwa_pkg::t_result w_res;
    logic             w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stale_ms    <= lwa_pkg::STALE_MS_RST;
            r_cfg.debounce_ms <= lwa_pkg::DEBOUNCE_MS_RST;
            r_cfg.watchdog_ms <= lwa_pkg::WATCHDOG_MS_RST;
            r_cfg.settle_ms   <= lwa_pkg::SETTLE_MS_RST;
        end else if (i_cfg_we) begin
            unique case (lwa_pkg::t_reg_index'(i_cfg_index))
                lwa_pkg::REG_STALE:    r_cfg.stale_ms    <= i_cfg_data;
                lwa_pkg::REG_DEBOUNCE: r_cfg.debounce_ms <= i_cfg_data;
                lwa_pkg::REG_WATCHDOG: r_cfg.watchdog_ms <= i_cfg_data;
                lwa_pkg::REG_SETTLE:   r_cfg.settle_ms   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The pipeline moves whenever the result register is empty or being taken.
    assign w_advance = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item.operation      <= i_in.operation;
            r_item.frame_valid    <= i_in.frame_valid;
            r_item.port_ready     <= i_in.port_ready;
            r_item.armed          <= i_in.armed;
            r_item.current_wiring <= i_in.current_wiring;
        end
    end

    lwa_core #(.COMBO_COUNT(COMBO_COUNT)) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (r_in_valid && w_advance),
        .i_item   (r_item),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_res <= w_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.trial_state    = r_res.trial_state;
    assign o_out.combo_index    = r_res.combo_index;
    assign o_out.applied_wiring = r_res.applied_wiring;
    assign o_out.elapsed_ms     = r_res.elapsed_ms;
    assign o_out.start_accepted = r_res.start_accepted;
    assign o_out.link_active    = r_res.link_active;

endmodule
`default_nettype wire

// ===== design/lwa_order.sv =====
// Trial order builder: ranks each combination by Hamming distance from the saved wiring.
`default_nettype none
module lwa_order #(
    parameter int COMBO_COUNT = lwa_pkg::COMBO_COUNT_DEF,
    parameter int IDX_W       = $clog2(COMBO_COUNT)
) (
    input  wire logic [2:0] i_saved,
    output logic      [2:0] o_order [COMBO_COUNT]
);

    logic [4:0]       w_key  [COMBO_COUNT];
    logic [IDX_W-1:0] w_rank [COMBO_COUNT];

    // The key orders by distance first and by value within one distance; keys are unique.
    always_comb begin
        for (int c = 0; c < COMBO_COUNT; c++) begin
            w_key[c] = {lwa_pkg::f_popcount3(3'(c) ^ i_saved), 3'(c)};
        end
        for (int c = 0; c < COMBO_COUNT; c++) begin
            w_rank[c] = '0;
            for (int k = 0; k < COMBO_COUNT; k++) begin
                if (w_key[k] < w_key[c]) begin
                    w_rank[c] = w_rank[c] + IDX_W'(1);
                end
            end
        end
        for (int p = 0; p < COMBO_COUNT; p++) begin
            o_order[p] = '0;
        end
        for (int c = 0; c < COMBO_COUNT; c++) begin
            o_order[w_rank[c]] = 3'(c);
        end
    end

endmodule
`default_nettype wire

// ===== design/lwa_core.sv =====
// Trial state and the update of that state for one registered item.
`default_nettype none
module lwa_core #(
    parameter int COMBO_COUNT = lwa_pkg::COMBO_COUNT_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire lwa_pkg::t_cfg   i_cfg,
    input  wire logic            i_valid,
    input  wire lwa_pkg::t_item  i_item,
    output lwa_pkg::t_result     o_result
);

    localparam int IDX_W = $clog2(COMBO_COUNT);

    logic [31:0]         r_now, n_now;
    logic [31:0]         r_lft, n_lft;
    logic                r_hvf, n_hvf;
    lwa_pkg::t_mode      r_mode, n_mode;
    logic [2:0]          r_pos, n_pos;
    logic [31:0]         r_cst, n_cst;
    logic [31:0]         r_since, n_since;
    logic                r_seen, n_seen;
    logic [31:0]         r_poll, n_poll;
    logic [2:0]          r_saved, n_saved;
    logic [2:0]          r_wiring, n_wiring;
    logic [2:0]          r_order [COMBO_COUNT];

    logic [2:0]          w_order [COMBO_COUNT];
    logic                w_write_order;
    logic [2:0]          w_pos_inc;
    logic [3:0]          w_pos_sum;
    logic [31:0]         w_diff;
    logic [31:0]         w_el;
    logic                w_live;
    logic                w_accepted;

    lwa_order #(.COMBO_COUNT(COMBO_COUNT), .IDX_W(IDX_W)) u_order (
        .i_saved (i_item.current_wiring),
        .o_order (w_order)
    );

    assign w_pos_inc = r_pos + 3'd1;
    assign w_pos_sum = {1'b0, r_pos} + 4'd1;

    always_comb begin
        n_now         = r_now;
        n_lft         = r_lft;
        n_hvf         = r_hvf;
        n_mode        = r_mode;
        n_pos         = r_pos;
        n_cst         = r_cst;
        n_since       = r_since;
        n_seen        = r_seen;
        n_poll        = r_poll;
        n_saved       = r_saved;
        n_wiring      = r_wiring;
        w_write_order = 1'b0;
        w_accepted    = 1'b0;
        w_diff        = '0;
        w_live        = 1'b0;

        unique case (lwa_pkg::t_op'(i_item.operation))
            lwa_pkg::OP_TICK: begin
                n_now = r_now + 32'd1;
                if (i_item.port_ready) begin
                    if (i_item.frame_valid) begin
                        n_hvf = 1'b1;
                        n_lft = n_now;
                    end
                    if (n_hvf && ((n_now - n_lft) >= {16'b0, i_cfg.stale_ms})) begin
                        n_hvf = 1'b0;
                    end
                end
                if (r_mode == lwa_pkg::MODE_RUNNING) begin
                    w_diff = n_now - r_poll;
                    w_live = i_item.port_ready && n_hvf &&
                             ((n_now - n_lft) < {16'b0, i_cfg.stale_ms});
                    if ($signed(w_diff) > $signed({16'b0, i_cfg.watchdog_ms})) begin
                        n_wiring = r_saved;
                        n_hvf    = 1'b0;
                        n_lft    = '0;
                        n_mode   = lwa_pkg::MODE_IDLE;
                    end else if (w_live) begin
                        if (!r_seen) begin
                            n_seen  = 1'b1;
                            n_since = n_now;
                        end else if ($signed(n_now - r_since) >=
                                     $signed({16'b0, i_cfg.debounce_ms})) begin
                            n_mode = lwa_pkg::MODE_SUCCESS;
                        end
                    end else begin
                        n_seen  = 1'b0;
                        n_since = '0;
                        if ($signed(n_now - r_cst) >= $signed({16'b0, i_cfg.settle_ms})) begin
                            if (w_pos_sum >= 4'(COMBO_COUNT)) begin
                                n_wiring = r_saved;
                                n_hvf    = 1'b0;
                                n_lft    = '0;
                                n_mode   = lwa_pkg::MODE_FAILED;
                            end else begin
                                n_pos    = w_pos_inc;
                                n_wiring = r_order[w_pos_inc[IDX_W-1:0]];
                                n_hvf    = 1'b0;
                                n_lft    = '0;
                                n_cst    = n_now;
                            end
                        end
                    end
                end
            end
            lwa_pkg::OP_START: begin
                if (r_mode != lwa_pkg::MODE_RUNNING) begin
                    if (i_item.armed || !i_item.port_ready) begin
                        n_mode = lwa_pkg::MODE_REJECTED;
                    end else begin
                        w_accepted    = 1'b1;
                        w_write_order = 1'b1;
                        n_saved       = i_item.current_wiring;
                        n_pos         = '0;
                        n_poll        = r_now;
                        n_mode        = lwa_pkg::MODE_RUNNING;
                        n_wiring      = w_order[0];
                        n_hvf         = 1'b0;
                        n_lft         = '0;
                        n_cst         = r_now;
                        n_seen        = 1'b0;
                        n_since       = '0;
                    end
                end
            end
            lwa_pkg::OP_STOP: begin
                if (r_mode != lwa_pkg::MODE_IDLE) begin
                    n_wiring = r_saved;
                    n_hvf    = 1'b0;
                    n_lft    = '0;
                    n_mode   = lwa_pkg::MODE_IDLE;
                end
            end
            lwa_pkg::OP_STATUS: begin
                n_poll = r_now;
            end
            default: begin
            end
        endcase
    end

    // Elapsed time is the signed difference, clamped to the 16-bit range.
    always_comb begin
        w_el = n_now - n_cst;
        o_result.trial_state    = n_mode;
        o_result.combo_index    = n_pos;
        o_result.applied_wiring = n_wiring;
        if (w_el[31]) begin
            o_result.elapsed_ms = '0;
        end else if (|w_el[30:16]) begin
            o_result.elapsed_ms = lwa_pkg::ELAPSED_MAX;
        end else begin
            o_result.elapsed_ms = w_el[15:0];
        end
        o_result.start_accepted = w_accepted;
        o_result.link_active    = i_item.port_ready && n_hvf &&
                                  ((n_now - n_lft) < {16'b0, i_cfg.stale_ms});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now    <= '0;
            r_lft    <= '0;
            r_hvf    <= 1'b0;
            r_mode   <= lwa_pkg::MODE_IDLE;
            r_pos    <= '0;
            r_cst    <= '0;
            r_since  <= '0;
            r_seen   <= 1'b0;
            r_poll   <= '0;
            r_saved  <= '0;
            r_wiring <= '0;
        end else if (i_valid) begin
            r_now    <= n_now;
            r_lft    <= n_lft;
            r_hvf    <= n_hvf;
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_cst    <= n_cst;
            r_since  <= n_since;
            r_seen   <= n_seen;
            r_poll   <= n_poll;
            r_saved  <= n_saved;
            r_wiring <= n_wiring;
        end
    end

    // The order list is only read while a trial runs, after a start has written it.
    always_ff @(posedge i_clk) begin
        if (i_valid && w_write_order) begin
            r_order <= w_order;
        end
    end

endmodule
`default_nettype wire
